[design/chc_pkg.sv]
// Shared types, constants and CORDIC angle table for the compass heading core.
`timescale 1ns / 1ps
package chc_pkg;

    localparam int AXIS_W     = 16;
    localparam int HEAD_W     = 15;
    localparam int DIV_STEPS  = 16;
    localparam int CORDIC_N   = 16;
    localparam int CXY_W      = 26;
    localparam int CZ_W       = 24;
    localparam int PIPE_DEPTH = 1 + DIV_STEPS + CORDIC_N + 2;

    localparam logic [2:0] REG_X_LO = 3'd0;
    localparam logic [2:0] REG_X_HI = 3'd1;
    localparam logic [2:0] REG_Y_LO = 3'd2;
    localparam logic [2:0] REG_Y_HI = 3'd3;
    localparam logic [2:0] REG_Z_LO = 3'd4;
    localparam logic [2:0] REG_Z_HI = 3'd5;

    localparam logic signed [CZ_W-1:0] Z_MAX      = 24'sd1474560;  // 90 deg
    localparam logic [23:0]            FINE_180   = 24'd2949120;
    localparam logic [23:0]            FINE_360   = 24'd5898240;
    localparam logic [15:0]            HEAD_FULL  = 16'd23040;
    localparam logic [HEAD_W-1:0]      HEAD_90    = 15'd5760;
    localparam logic [HEAD_W-1:0]      HEAD_270   = 15'd17280;
    localparam logic [AXIS_W-1:0]      Q_ONE      = 16'd16384;

    // atan(2^-i) in 1/16384 degree
    localparam logic signed [CZ_W-1:0] ATAN_TAB [CORDIC_N] = '{
        24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736,
        24'sd58595,  24'sd29326,  24'sd14667,  24'sd7334,
        24'sd3667,   24'sd1833,   24'sd917,    24'sd458,
        24'sd229,    24'sd115,    24'sd57,     24'sd29
    };

    typedef struct packed {
        logic signed [AXIS_W-1:0] nx;
        logic signed [AXIS_W-1:0] ny;
        logic signed [AXIS_W-1:0] nz;
    } chc_norm_t;

endpackage

[design/chc_div.sv]
// Pipelined restoring divider producing one normalized axis value per cycle while en is high.
`timescale 1ns / 1ps
module chc_div
    import chc_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [AXIS_W-1:0]        num,
    input  logic [AXIS_W-1:0]        span,
    input  logic                     empty,
    output logic signed [AXIS_W-1:0] norm
);

    logic [17:0]       rem_reg   [DIV_STEPS];
    logic [AXIS_W-1:0] quo_reg   [DIV_STEPS];
    logic [AXIS_W-1:0] span_reg  [DIV_STEPS];
    logic              empty_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [17:0]       rem_in;
            logic [AXIS_W-1:0] quo_in;
            logic [AXIS_W-1:0] span_in;
            logic              empty_in;
            logic [17:0]       rem_sh;
            logic [17:0]       dvs;
            logic [17:0]       rem_next;
            logic              bit_next;

            if (k == 0)
            begin : g_first
                assign rem_in   = {2'b00, num};
                assign quo_in   = '0;
                assign span_in  = span;
                assign empty_in = empty;
            end
            else
            begin : g_rest
                assign rem_in   = rem_reg[k-1];
                assign quo_in   = quo_reg[k-1];
                assign span_in  = span_reg[k-1];
                assign empty_in = empty_reg[k-1];
            end

            always_comb
            begin
                // shift in the next bit of the low half of the dividend (the span)
                rem_sh   = {rem_in[16:0], span_in[DIV_STEPS-1-k]};
                dvs      = {1'b0, span_in, 1'b0};
                bit_next = (rem_sh >= dvs);
                rem_next = bit_next ? (rem_sh - dvs) : rem_sh;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]   <= rem_next;
                    quo_reg[k]   <= {quo_in[AXIS_W-2:0], bit_next};
                    span_reg[k]  <= span_in;
                    empty_reg[k] <= empty_in;
                end
            end
        end
    endgenerate

    assign norm = empty_reg[DIV_STEPS-1] ? '0 : $signed(quo_reg[DIV_STEPS-1] - Q_ONE);

endmodule

[design/chc_cordic.sv]
// Pipelined vectoring CORDIC and quadrant fold giving the heading.
`timescale 1ns / 1ps
module chc_cordic
    import chc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  chc_norm_t         norm_in,
    output logic [HEAD_W-1:0] heading,
    output chc_norm_t         norm_out
);

    logic signed [CXY_W-1:0] x_reg [CORDIC_N+1];
    logic signed [CXY_W-1:0] y_reg [CORDIC_N+1];
    logic signed [CZ_W-1:0]  z_reg [CORDIC_N+1];
    chc_norm_t               side_reg [CORDIC_N+1];
    logic [HEAD_W-1:0]       head_reg;
    chc_norm_t               out_reg;

    logic [AXIS_W-1:0] abs_x;
    logic [AXIS_W-1:0] abs_y;

    always_comb
    begin
        abs_x = norm_in.nx[AXIS_W-1] ? 16'(-norm_in.nx) : norm_in.nx;
        abs_y = norm_in.ny[AXIS_W-1] ? 16'(-norm_in.ny) : norm_in.ny;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= $signed({2'b00, abs_y, 8'h00});
            y_reg[0]    <= $signed({2'b00, abs_x, 8'h00});
            z_reg[0]    <= '0;
            side_reg[0] <= norm_in;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_N; i++)
        begin : g_iter
            logic signed [CXY_W-1:0] dx;
            logic signed [CXY_W-1:0] dy;
            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!y_reg[i][CXY_W-1])
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                    end
                    side_reg[i+1] <= side_reg[i];
                end
            end
        end
    endgenerate

    logic [23:0]       phi;
    logic [23:0]       fine;
    logic [15:0]       coarse;
    logic [HEAD_W-1:0] head_next;
    chc_norm_t         last;

    always_comb
    begin
        last = side_reg[CORDIC_N];
        if (z_reg[CORDIC_N][CZ_W-1])
            phi = '0;
        else if (z_reg[CORDIC_N] > Z_MAX)
            phi = 24'(Z_MAX);
        else
            phi = 24'(z_reg[CORDIC_N]);

        if (!last.ny[AXIS_W-1])
            fine = last.nx[AXIS_W-1] ? (FINE_360 - phi) : phi;
        else
            fine = last.nx[AXIS_W-1] ? (FINE_180 + phi) : (FINE_180 - phi);

        coarse = 16'((fine + 24'd128) >> 8);
        if (coarse >= HEAD_FULL)
            coarse = coarse - HEAD_FULL;

        if (last.ny == '0)
        begin
            if (last.nx == '0)
                head_next = '0;
            else if (last.nx[AXIS_W-1])
                head_next = HEAD_270;
            else
                head_next = HEAD_90;
        end
        else
        begin
            head_next = coarse[HEAD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
            out_reg  <= last;
        end
    end

    assign heading  = head_reg;
    assign norm_out = out_reg;

endmodule

[design/compass_heading_calibrated_core.sv]
// Top level of the calibrated compass heading core.
`timescale 1ns / 1ps
// Each raw sample is clamped to its axis calibration window, scaled to Q1.14 by a
// 16-stage pipelined divider per axis, and folded into a 0..360 degree heading
// (1/64 degree units) by a 16-stage CORDIC. A sample can be taken every cycle while
// the output is not stalled; a stall holds every stage. A result passes the clamp,
// divider and CORDIC registers. Limits are written through the cfg port (indexes 0..5:
// x low, x high, y low, y high, z low, z high); write only while the core is empty.
module compass_heading_calibrated_core
    import chc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mag_x[15:0], mag_y[31:16], mag_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // heading[14:0], norm_x[30:15], norm_y[46:31],
                                   // norm_z[62:47], zero[63]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic signed [AXIS_W-1:0] lim_reg [6];
    logic [PIPE_DEPTH-1:0]    vld_reg;
    logic                     adv;

    assign adv       = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg[REG_X_LO] <= -16'sd220;
            lim_reg[REG_X_HI] <= 16'sd170;
            lim_reg[REG_Y_LO] <= -16'sd310;
            lim_reg[REG_Y_HI] <= 16'sd40;
            lim_reg[REG_Z_LO] <= -16'sd480;
            lim_reg[REG_Z_HI] <= 16'sd480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_LO, REG_X_HI, REG_Y_LO, REG_Y_HI, REG_Z_LO, REG_Z_HI:
                    lim_reg[cfg_index] <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
    end

    // clamp each axis and form the dividend and span of the scaling
    logic [AXIS_W-1:0] num_reg   [3];
    logic [AXIS_W-1:0] span_reg  [3];
    logic              empty_reg [3];
    logic signed [AXIS_W-1:0] norm [3];

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            logic signed [AXIS_W-1:0] raw;
            logic signed [AXIS_W-1:0] lo;
            logic signed [AXIS_W-1:0] hi;
            logic signed [AXIS_W-1:0] v;
            logic                     empty_next;
            logic [AXIS_W:0]          diff;
            logic [AXIS_W:0]          off;

            always_comb
            begin
                raw = $signed(s_tdata[a*AXIS_W +: AXIS_W]);
                lo  = lim_reg[2*a];
                hi  = lim_reg[2*a+1];
                empty_next = (hi <= lo);
                if (raw < lo)
                    v = lo;
                else if (raw > hi)
                    v = hi;
                else
                    v = raw;
                diff = 17'({hi[AXIS_W-1], hi} - {lo[AXIS_W-1], lo});
                off  = 17'({v[AXIS_W-1], v} - {lo[AXIS_W-1], lo});
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    empty_reg[a] <= empty_next;
                    num_reg[a]   <= empty_next ? '0 : off[AXIS_W-1:0];
                    span_reg[a]  <= empty_next ? 16'd1 : diff[AXIS_W-1:0];
                end
            end

            chc_div u_div (
                .clk   (clk),
                .en    (adv),
                .num   (num_reg[a]),
                .span  (span_reg[a]),
                .empty (empty_reg[a]),
                .norm  (norm[a])
            );
        end
    endgenerate

    chc_norm_t         norm_in;
    chc_norm_t         norm_out;
    logic [HEAD_W-1:0] heading;

    assign norm_in.nx = norm[0];
    assign norm_in.ny = norm[1];
    assign norm_in.nz = norm[2];

    chc_cordic u_cordic (
        .clk      (clk),
        .en       (adv),
        .norm_in  (norm_in),
        .heading  (heading),
        .norm_out (norm_out)
    );

    assign m_tdata = {1'b0, norm_out.nz, norm_out.ny, norm_out.nx, heading};

endmodule
